// ===== sv/rle_24bit_symbol_stream_decoder_top_assert.svh =====
// Assertion macros used by the decoder's top-level RTL file.
`ifndef RLE_24BIT_SYMBOL_STREAM_DECODER_TOP_ASSERT_SVH
`define RLE_24BIT_SYMBOL_STREAM_DECODER_TOP_ASSERT_SVH

// A property that must hold at every clock edge outside reset.
`define RSD_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
    else $error("rsd assertion failed");

// A condition that must hold in the same cycle as its trigger.
`define RSD_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("rsd assertion failed");

`endif

// ===== sv/rsd_pkg.sv =====
// Types, constants and codes shared by the run-length decoder modules.
package rsd_pkg;

  localparam int SymBytes      = 3;
  localparam int ShortMinRange = (3 + 1 + 1) + 2;
  localparam int RepeatBias    = ShortMinRange / SymBytes - 1;

  localparam int FifoDepth = 4;
  localparam int FifoPtrW  = $clog2(FifoDepth);
  localparam int FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    KindLit = 2'd0,
    KindRun = 2'd1,
    KindEnd = 2'd2,
    KindErr = 2'd3
  } kind_e;

  typedef enum logic {
    CfgOutputCapacity = 1'b0,
    CfgInputCapacity  = 1'b1
  } cfg_index_e;

  typedef struct packed {
    kind_e       kind;
    logic [7:0]  literal_byte;
    logic [23:0] run_symbol;
    logic [32:0] run_repeats;
    logic [31:0] original_size;
    logic        last;
  } result_t;

  typedef struct packed {
    logic [1:0] count;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

// ===== sv/rle_24bit_symbol_stream_decoder_top.sv =====
// Top level of the run-length decoder for streams of 24-bit symbols.
//
// Usage:
// The input channel (in_valid_i, in_stall_o) carries one compressed byte per
// request, with stream_start_i set on the first header byte of a stream.
// The output channel (out_valid_o, out_stall_i) carries one result per
// request: a literal byte, a run descriptor, a stream end or a header error.
// A byte causes zero, one or two results; last_o marks the final one.
// The capacity registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i while no stream byte is in flight.
// An accepted byte is registered, then its results are registered in the queue.
// One byte is taken every cycle as long as results drain at the same pace;
// a literal that ends a token adds one extra result to the four-entry queue.
// The input side stalls when the queue has fewer than two free entries.
// A stalled output holds its result and fills the queue, which then stalls
// the input. Reset halts the parser until a stream start, empties the queue
// and sets both capacities to their largest value.
`include "rle_24bit_symbol_stream_decoder_top_assert.svh"

module rle_24bit_symbol_stream_decoder_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [31:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        stream_start_i,
  input  logic [7:0]  in_byte_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [1:0]  kind_o,
  output logic [7:0]  literal_byte_o,
  output logic [23:0] run_symbol_o,
  output logic [32:0] run_repeats_o,
  output logic [31:0] original_size_o,
  output logic        last_o
);

  logic [31:0]                  out_cap_q;
  logic [31:0]                  in_cap_q;
  logic                         in_valid_q, in_valid_d;
  logic                         start_q;
  logic [7:0]                   byte_q;
  logic                         room;
  logic                         fire;
  logic                         accept;
  logic                         pop;
  rsd_pkg::push_t               push;
  rsd_pkg::result_t             head;
  logic [rsd_pkg::FifoCntW-1:0] fifo_count;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cap_q <= '1;
      in_cap_q  <= '1;
    end else if (cfg_we_i) begin
      unique case (rsd_pkg::cfg_index_e'(cfg_index_i))
        rsd_pkg::CfgOutputCapacity: out_cap_q <= cfg_data_i;
        rsd_pkg::CfgInputCapacity:  in_cap_q  <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign room       = fifo_count <= rsd_pkg::FifoCntW'(rsd_pkg::FifoDepth - 2);
  assign fire       = in_valid_q && room;
  assign in_stall_o = in_valid_q && !room;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (fire) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      start_q <= stream_start_i;
      byte_q  <= in_byte_i;
    end
  end

  rsd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (fire),
    .start_i   (start_q),
    .byte_i    (byte_q),
    .out_cap_i (out_cap_q),
    .in_cap_i  (in_cap_q),
    .push_o    (push)
  );

  assign out_valid_o = fifo_count != '0;
  assign pop         = out_valid_o && !out_stall_i;

  rsd_result_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .pop_i   (pop),
    .head_o  (head),
    .count_o (fifo_count)
  );

  assign kind_o          = head.kind;
  assign literal_byte_o  = head.literal_byte;
  assign run_symbol_o    = head.run_symbol;
  assign run_repeats_o   = head.run_repeats;
  assign original_size_o = head.original_size;
  assign last_o          = head.last;

  `RSD_ASSERT(a_fifo_bound, clk_i, rst_ni,
              fifo_count <= rsd_pkg::FifoCntW'(rsd_pkg::FifoDepth))
  `RSD_ASSERT_IMPL(a_push_room, clk_i, rst_ni, push.count != 2'd0,
                   fifo_count <= rsd_pkg::FifoCntW'(rsd_pkg::FifoDepth - 2))
  `RSD_ASSERT_IMPL(a_pair_starts_literal, clk_i, rst_ni, push.count == 2'd2,
                   push.r0.kind == rsd_pkg::KindLit && !push.r0.last && push.r1.last)

endmodule

// ===== sv/rsd_parser.sv =====
// Header and token parser: holds the stream state and makes up to two results per byte.
module rsd_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic                start_i,
  input  logic [7:0]          byte_i,
  input  logic [31:0]         out_cap_i,
  input  logic [31:0]         in_cap_i,
  output rsd_pkg::push_t      push_o
);

  typedef enum logic [3:0] {
    PhHalt    = 4'd0,
    PhHdrOrig = 4'd1,
    PhHdrComp = 4'd2,
    PhSym     = 4'd3,
    PhCnt     = 4'd4,
    PhCntExt  = 4'd5,
    PhOfs     = 4'd6,
    PhOfsExt  = 4'd7,
    PhLit     = 4'd8
  } phase_e;

  phase_e      phase_q, phase_d;
  logic [1:0]  pos_q, pos_d;
  logic [31:0] acc_q, acc_d;
  logic [31:0] orig_q, orig_d;
  logic [23:0] sym_q, sym_d;
  logic [31:0] count_q, count_d;
  logic [31:0] lit_q, lit_d;

  phase_e           ph;
  logic [1:0]       pos;
  logic [31:0]      acc;
  logic [31:0]      acc_g;
  logic [31:0]      offset;
  logic [31:0]      left;
  rsd_pkg::result_t fin_res;
  phase_e           fin_phase;
  rsd_pkg::push_t   push;

  function automatic rsd_pkg::result_t mk(rsd_pkg::kind_e kind, logic [7:0] lit,
                                          logic [23:0] sym, logic [32:0] rep,
                                          logic [31:0] orig);
    rsd_pkg::result_t r;
    r.kind          = kind;
    r.literal_byte  = lit;
    r.run_symbol    = sym;
    r.run_repeats   = rep;
    r.original_size = orig;
    r.last          = 1'b0;
    return r;
  endfunction

  always_comb begin
    if (count_q == 32'd0) begin
      fin_res   = mk(rsd_pkg::KindEnd, 8'd0, 24'd0, 33'd0, orig_q);
      fin_phase = PhHalt;
    end else begin
      fin_res   = mk(rsd_pkg::KindRun, 8'd0, sym_q,
                     33'(count_q) + 33'(rsd_pkg::RepeatBias), 32'd0);
      fin_phase = PhSym;
    end
  end

  always_comb begin
    ph  = start_i ? PhHdrOrig : phase_q;
    pos = start_i ? 2'd0 : pos_q;
    acc = start_i ? 32'd0 : acc_q;

    if (pos == 2'd0) begin
      acc_g = 32'(byte_i);
    end else begin
      acc_g = acc | (32'(byte_i) << {pos, 3'b000});
    end

    phase_d    = ph;
    pos_d      = pos;
    acc_d      = acc;
    orig_d     = orig_q;
    sym_d      = sym_q;
    count_d    = count_q;
    lit_d      = lit_q;
    offset     = 32'd0;
    left       = 32'd0;
    push.count = 2'd0;
    push.r0    = mk(rsd_pkg::KindLit, 8'd0, 24'd0, 33'd0, 32'd0);
    push.r1    = mk(rsd_pkg::KindLit, 8'd0, 24'd0, 33'd0, 32'd0);

    unique case (ph)
      PhHalt: begin
      end
      PhHdrOrig: begin
        acc_d = acc_g;
        if (pos == 2'd3) begin
          pos_d   = 2'd0;
          orig_d  = acc_g;
          phase_d = PhHdrComp;
        end else begin
          pos_d = pos + 2'd1;
        end
      end
      PhHdrComp: begin
        acc_d = acc_g;
        if (pos == 2'd3) begin
          pos_d = 2'd0;
          if (orig_q > out_cap_i || acc_g > in_cap_i ||
              out_cap_i == 32'd0 || in_cap_i == 32'd0) begin
            phase_d    = PhHalt;
            push.count = 2'd1;
            push.r0    = mk(rsd_pkg::KindErr, 8'd0, 24'd0, 33'd0, 32'd0);
          end else begin
            phase_d = PhSym;
          end
        end else begin
          pos_d = pos + 2'd1;
        end
      end
      PhSym: begin
        acc_d = acc_g;
        if (pos == 2'(rsd_pkg::SymBytes - 1)) begin
          pos_d   = 2'd0;
          sym_d   = acc_g[23:0];
          phase_d = PhCnt;
        end else begin
          pos_d = pos + 2'd1;
        end
      end
      PhCnt: begin
        if (byte_i == 8'd0) begin
          phase_d = PhCntExt;
          pos_d   = 2'd0;
        end else begin
          count_d = 32'(byte_i);
          phase_d = PhOfs;
        end
      end
      PhCntExt: begin
        acc_d = acc_g;
        if (pos == 2'd3) begin
          pos_d   = 2'd0;
          count_d = acc_g;
          phase_d = PhOfs;
        end else begin
          pos_d = pos + 2'd1;
        end
      end
      PhOfs, PhOfsExt: begin
        if (ph == PhOfs) begin
          offset = 32'(byte_i);
          if (byte_i == 8'd0) begin
            phase_d = PhOfsExt;
            pos_d   = 2'd0;
          end
        end else begin
          acc_d  = acc_g;
          offset = acc_g;
          if (pos == 2'd3) begin
            pos_d = 2'd0;
            if (acc_g == 32'd0) begin
              phase_d    = PhHalt;
              push.count = 2'd1;
              push.r0    = mk(rsd_pkg::KindEnd, 8'd0, 24'd0, 33'd0, orig_q);
            end
          end else begin
            pos_d = pos + 2'd1;
          end
        end
        if ((ph == PhOfs && byte_i != 8'd0) ||
            (ph == PhOfsExt && pos == 2'd3 && acc_g != 32'd0)) begin
          left  = offset - 32'd1;
          lit_d = left;
          if (left == 32'd0) begin
            phase_d    = fin_phase;
            pos_d      = 2'd0;
            push.count = 2'd1;
            push.r0    = fin_res;
          end else begin
            phase_d = PhLit;
          end
        end
      end
      PhLit: begin
        left       = lit_q - 32'd1;
        lit_d      = left;
        push.count = 2'd1;
        push.r0    = mk(rsd_pkg::KindLit, byte_i, 24'd0, 33'd0, 32'd0);
        if (left == 32'd0) begin
          phase_d    = fin_phase;
          pos_d      = 2'd0;
          push.count = 2'd2;
          push.r1    = fin_res;
        end
      end
      default: begin
        phase_d = PhHalt;
      end
    endcase

    push.r0.last = (push.count == 2'd1);
    push.r1.last = (push.count == 2'd2);
    if (!fire_i) begin
      push.count = 2'd0;
    end
  end

  assign push_o = push;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhHalt;
      pos_q   <= 2'd0;
      acc_q   <= 32'd0;
      orig_q  <= 32'd0;
      sym_q   <= 24'd0;
      count_q <= 32'd0;
      lit_q   <= 32'd0;
    end else if (fire_i) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      acc_q   <= acc_d;
      orig_q  <= orig_d;
      sym_q   <= sym_d;
      count_q <= count_d;
      lit_q   <= lit_d;
    end
  end

endmodule

// ===== sv/rsd_result_fifo.sv =====
// Small result queue that takes up to two results a cycle and gives one.
module rsd_result_fifo (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  rsd_pkg::push_t                   push_i,
  input  logic                             pop_i,
  output rsd_pkg::result_t                 head_o,
  output logic [rsd_pkg::FifoCntW-1:0]     count_o
);

  rsd_pkg::result_t                 slots_q [rsd_pkg::FifoDepth];
  logic [rsd_pkg::FifoPtrW-1:0]     wr_q, wr_d;
  logic [rsd_pkg::FifoPtrW-1:0]     rd_q, rd_d;
  logic [rsd_pkg::FifoCntW-1:0]     count_q, count_d;

  always_comb begin
    wr_d    = wr_q + rsd_pkg::FifoPtrW'(push_i.count);
    rd_d    = rd_q + rsd_pkg::FifoPtrW'(pop_i);
    count_d = count_q + rsd_pkg::FifoCntW'(push_i.count) - rsd_pkg::FifoCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q    <= '0;
      rd_q    <= '0;
      count_q <= '0;
    end else begin
      wr_q    <= wr_d;
      rd_q    <= rd_d;
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      slots_q[wr_q] <= push_i.r0;
    end
    if (push_i.count == 2'd2) begin
      slots_q[wr_q + rsd_pkg::FifoPtrW'(1)] <= push_i.r1;
    end
  end

  assign head_o  = slots_q[rd_q];
  assign count_o = count_q;

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the 24-bit symbol run-length stream decoder.
module testbench;

  localparam int QuietLimit = 3000;

  typedef enum logic [3:0] {
    PhHalt,
    PhHdrOrig,
    PhHdrComp,
    PhSym,
    PhCnt,
    PhCntExt,
    PhOfs,
    PhOfsExt,
    PhLit
  } parse_phase_e;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_index_i;
  logic [31:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic        stream_start_i;
  logic [7:0]  in_byte_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [1:0]  kind_o;
  logic [7:0]  literal_byte_o;
  logic [23:0] run_symbol_o;
  logic [32:0] run_repeats_o;
  logic [31:0] original_size_o;
  logic        last_o;

  rle_24bit_symbol_stream_decoder_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .stream_start_i (stream_start_i),
    .in_byte_i      (in_byte_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .kind_o         (kind_o),
    .literal_byte_o (literal_byte_o),
    .run_symbol_o   (run_symbol_o),
    .run_repeats_o  (run_repeats_o),
    .original_size_o(original_size_o),
    .last_o         (last_o)
  );

  // Decoder state mirrored for prediction.
  parse_phase_e phase_q;
  logic [1:0]   field_pos;
  logic [31:0]  field_acc;
  logic [31:0]  hdr_orig_size;
  logic [23:0]  tok_symbol;
  logic [31:0]  tok_count;
  logic [31:0]  lits_left;
  logic [31:0]  out_cap;
  logic [31:0]  in_cap;

  rsd_pkg::result_t step_out[2];
  int               step_n;
  rsd_pkg::result_t decoded_results[$];
  logic [7:0]       stream_bytes[$];

  int stream_items;
  int mismatch_count;
  int hold_req;
  bit tx_no_gaps;
  bit rx_no_stalls;

  always #6 clk_i = ~clk_i;

  function automatic void emit(rsd_pkg::kind_e kind, logic [7:0] lit, logic [23:0] sym,
                               logic [32:0] rep, logic [31:0] orig);
    rsd_pkg::result_t r;
    r.kind = kind;
    r.literal_byte = lit;
    r.run_symbol = sym;
    r.run_repeats = rep;
    r.original_size = orig;
    r.last = 1'b0;
    step_out[step_n] = r;
    step_n++;
  endfunction

  function automatic bit gather(logic [7:0] data, int nbytes);
    if (field_pos == 2'd0) begin
      field_acc = {24'd0, data};
    end else begin
      field_acc = field_acc | ({24'd0, data} << (8 * field_pos));
    end
    if (int'(field_pos) + 1 >= nbytes) begin
      field_pos = 2'd0;
      return 1'b1;
    end
    field_pos = field_pos + 2'd1;
    return 1'b0;
  endfunction

  function automatic void close_token();
    if (tok_count == 32'd0) begin
      phase_q = PhHalt;
      emit(rsd_pkg::KindEnd, 8'd0, 24'd0, 33'd0, hdr_orig_size);
    end else begin
      phase_q = PhSym;
      field_pos = 2'd0;
      emit(rsd_pkg::KindRun, 8'd0, tok_symbol,
           {1'b0, tok_count} + 33'(rsd_pkg::RepeatBias), 32'd0);
    end
  endfunction

  function automatic void open_literals(logic [31:0] offset);
    lits_left = offset - 32'd1;
    if (lits_left == 32'd0) begin
      close_token();
    end else begin
      phase_q = PhLit;
    end
  endfunction

  // Works out the results that one accepted byte causes.
  function automatic void decode_byte(logic start, logic [7:0] data);
    step_n = 0;
    if (start || phase_q != PhHalt) begin
      stream_items++;
    end
    if (start) begin
      phase_q = PhHdrOrig;
      field_pos = 2'd0;
      field_acc = 32'd0;
    end
    case (phase_q)
      PhHdrOrig: begin
        if (gather(data, 4)) begin
          hdr_orig_size = field_acc;
          phase_q = PhHdrComp;
        end
      end
      PhHdrComp: begin
        if (gather(data, 4)) begin
          if (hdr_orig_size > out_cap || field_acc > in_cap ||
              out_cap == 32'd0 || in_cap == 32'd0) begin
            phase_q = PhHalt;
            emit(rsd_pkg::KindErr, 8'd0, 24'd0, 33'd0, 32'd0);
          end else begin
            phase_q = PhSym;
          end
        end
      end
      PhSym: begin
        if (gather(data, rsd_pkg::SymBytes)) begin
          tok_symbol = field_acc[23:0];
          phase_q = PhCnt;
        end
      end
      PhCnt: begin
        if (data == 8'd0) begin
          phase_q = PhCntExt;
          field_pos = 2'd0;
        end else begin
          tok_count = {24'd0, data};
          phase_q = PhOfs;
        end
      end
      PhCntExt: begin
        if (gather(data, 4)) begin
          tok_count = field_acc;
          phase_q = PhOfs;
        end
      end
      PhOfs: begin
        if (data == 8'd0) begin
          phase_q = PhOfsExt;
          field_pos = 2'd0;
        end else begin
          open_literals({24'd0, data});
        end
      end
      PhOfsExt: begin
        if (gather(data, 4)) begin
          if (field_acc == 32'd0) begin
            phase_q = PhHalt;
            emit(rsd_pkg::KindEnd, 8'd0, 24'd0, 33'd0, hdr_orig_size);
          end else begin
            open_literals(field_acc);
          end
        end
      end
      PhLit: begin
        emit(rsd_pkg::KindLit, data, 24'd0, 33'd0, 32'd0);
        lits_left = lits_left - 32'd1;
        if (lits_left == 32'd0) begin
          close_token();
        end
      end
      default: phase_q = PhHalt;
    endcase
    if (step_n > 0) begin
      step_out[step_n - 1].last = 1'b1;
    end
    for (int i = 0; i < step_n; i++) begin
      decoded_results.push_back(step_out[i]);
    end
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (mismatch_count < 40) begin
      $display("%0t: mismatch in %s: got %0h, want %0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic check_result();
    rsd_pkg::result_t want;
    if (decoded_results.size() == 0) begin
      report_mismatch("result with nothing pending", 64'(kind_o), 64'd0);
      return;
    end
    want = decoded_results.pop_front();
    if (kind_o !== want.kind) report_mismatch("kind", 64'(kind_o), 64'(want.kind));
    if (literal_byte_o !== want.literal_byte) begin
      report_mismatch("literal_byte", 64'(literal_byte_o), 64'(want.literal_byte));
    end
    if (run_symbol_o !== want.run_symbol) begin
      report_mismatch("run_symbol", 64'(run_symbol_o), 64'(want.run_symbol));
    end
    if (run_repeats_o !== want.run_repeats) begin
      report_mismatch("run_repeats", 64'(run_repeats_o), 64'(want.run_repeats));
    end
    if (original_size_o !== want.original_size) begin
      report_mismatch("original_size", 64'(original_size_o), 64'(want.original_size));
    end
    if (last_o !== want.last) report_mismatch("last", 64'(last_o), 64'(want.last));
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      check_result();
    end
  end

  // Output side: a random stall after each accepted result unless rx_no_stalls is set, plus long hold-offs on request.
  initial begin : receiver
    int drain_wait;
    int hold_left;
    out_stall_i = 1'b0;
    drain_wait = 0;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req > 0) begin
        hold_left = hold_req;
        hold_req = 0;
      end
      if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
        drain_wait = rx_no_stalls ? 0 : $urandom_range(0, 13);
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (drain_wait > 0) begin
        drain_wait--;
        out_stall_i <= 1'b1;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i === 1'b1 && in_stall_o === 1'b0) ||
          (out_valid_o === 1'b1 && out_stall_i === 1'b0)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  task automatic send_byte(input logic start, input logic [7:0] data);
    int gap;
    gap = tx_no_gaps ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    stream_start_i <= start;
    in_byte_i <= data;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    decode_byte(start, data);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (decoded_results.size() != 0);
  endtask

  task automatic settle();
    drain_results();
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_caps(input logic [31:0] out_value, input logic [31:0] in_value);
    cfg_we_i <= 1'b1;
    cfg_index_i <= rsd_pkg::CfgOutputCapacity;
    cfg_data_i <= out_value;
    @(posedge clk_i);
    out_cap = out_value;
    cfg_index_i <= rsd_pkg::CfgInputCapacity;
    cfg_data_i <= in_value;
    @(posedge clk_i);
    in_cap = in_value;
    cfg_we_i <= 1'b0;
  endtask

  function automatic void add_le32(logic [31:0] value);
    stream_bytes.push_back(value[7:0]);
    stream_bytes.push_back(value[15:8]);
    stream_bytes.push_back(value[23:16]);
    stream_bytes.push_back(value[31:24]);
  endfunction

  function automatic void add_token(logic [23:0] sym, logic [31:0] cnt, bit cnt_ext,
                                    logic [31:0] ofs, bit ofs_ext);
    stream_bytes.push_back(sym[7:0]);
    stream_bytes.push_back(sym[15:8]);
    stream_bytes.push_back(sym[23:16]);
    if (cnt_ext) begin
      stream_bytes.push_back(8'd0);
      add_le32(cnt);
    end else begin
      stream_bytes.push_back(cnt[7:0]);
    end
    if (ofs_ext) begin
      stream_bytes.push_back(8'd0);
      add_le32(ofs);
    end else begin
      stream_bytes.push_back(ofs[7:0]);
    end
  endfunction

  function automatic void add_literals(int n);
    for (int i = 0; i < n; i++) begin
      stream_bytes.push_back(8'($urandom_range(0, 255)));
    end
  endfunction

  task automatic send_stream(input int pause_at);
    for (int i = 0; i < stream_bytes.size(); i++) begin
      if (i == pause_at) drain_results();
      send_byte(i == 0, stream_bytes[i]);
    end
  endtask

  function automatic logic [31:0] pick_size(logic [31:0] cap);
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return $urandom_range(0, cap);
    if (r < 15) return cap;
    if (r < 18) return cap + 32'd1;
    return $urandom;
  endfunction

  function automatic logic [31:0] pick_cap();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 5) return 32'hFFFF_FFFF;
    if (r < 8) return $urandom;
    if (r < 9) return 32'd0;
    return $urandom_range(0, 1000);
  endfunction

  task automatic play_random_stream();
    int ntok;
    int cut;
    int pause_at;
    int unsigned r;
    logic [31:0] cnt;
    logic [31:0] ofs;
    bit cnt_ext;
    bit ofs_ext;
    tx_no_gaps = ($urandom_range(0, 4) == 0);
    rx_no_stalls = ($urandom_range(0, 4) == 0);
    if ($urandom_range(0, 5) == 0) begin
      repeat ($urandom_range(1, 3)) begin
        send_byte($urandom_range(0, 7) == 0, 8'($urandom_range(0, 255)));
      end
    end
    stream_bytes.delete();
    add_le32(pick_size(out_cap));
    add_le32(pick_size(in_cap));
    ntok = $urandom_range(0, 5);
    for (int t = 0; t <= ntok; t++) begin
      r = $urandom_range(0, 9);
      if (r < 6) begin
        cnt_ext = 1'b0;
        cnt = $urandom_range(1, 255);
      end else if (r < 8) begin
        cnt_ext = 1'b1;
        cnt = $urandom;
      end else begin
        cnt_ext = 1'b1;
        cnt = $urandom_range(1, 300);
      end
      r = $urandom_range(0, 19);
      if (r < 14) begin
        ofs_ext = 1'b0;
        ofs = $urandom_range(1, 10);
      end else if (r < 15) begin
        ofs_ext = 1'b0;
        ofs = $urandom_range(11, 255);
      end else begin
        ofs_ext = 1'b1;
        ofs = $urandom_range(1, 12);
      end
      if (t == ntok) begin
        if ($urandom_range(0, 1) == 0) begin
          ofs_ext = 1'b1;
          ofs = 32'd0;
        end else begin
          cnt_ext = 1'b1;
          cnt = 32'd0;
        end
      end
      add_token(24'($urandom), cnt, cnt_ext, ofs, ofs_ext);
      if (ofs != 32'd0) add_literals(int'(ofs) - 1);
    end
    if ($urandom_range(0, 7) == 0) begin
      cut = $urandom_range(1, stream_bytes.size() - 1);
      while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
    end
    pause_at = ($urandom_range(0, 9) == 0) ? $urandom_range(1, stream_bytes.size() - 1) : -1;
    send_stream(pause_at);
  endtask

  task automatic test_halted_bytes();
    send_byte(1'b0, 8'h00);
    send_byte(1'b0, 8'hFF);
  endtask

  task automatic test_token_forms();
    stream_bytes.delete();
    add_le32(32'hDEAD_BEEF);
    add_le32(32'h0000_0040);
    add_token(24'hFF_FFFF, 32'd255, 1'b0, 32'd2, 1'b0);
    stream_bytes.push_back(8'hFF);
    add_token(24'h00_0000, 32'hFFFF_FFFF, 1'b1, 32'd1, 1'b0);
    add_token(24'h12_3456, 32'd1, 1'b0, 32'd0, 1'b1);
    send_stream(-1);
  endtask

  task automatic test_end_by_count();
    stream_bytes.delete();
    add_le32(32'd0);
    add_le32(32'd0);
    add_token(24'hAB_CDEF, 32'd0, 1'b1, 32'd3, 1'b0);
    stream_bytes.push_back(8'h00);
    stream_bytes.push_back(8'hFF);
    send_stream(-1);
  endtask

  task automatic test_restart_mid_stream();
    stream_bytes.delete();
    add_le32(32'd5);
    add_le32(32'd5);
    add_token(24'h01_0203, 32'd5, 1'b0, 32'hFFFF_FFFF, 1'b1);
    add_literals(3);
    send_stream(-1);
    stream_bytes.delete();
    add_le32(32'h0102_0304);
    send_stream(-1);
    stream_bytes.delete();
    add_le32(32'd9);
    add_le32(32'd9);
    add_token(24'h00_FF00, 32'd2, 1'b0, 32'd1, 1'b0);
    add_token(24'h00_0000, 32'd7, 1'b0, 32'd0, 1'b1);
    send_stream(-1);
  endtask

  task automatic test_header_limits();
    settle();
    write_caps(32'd0, 32'hFFFF_FFFF);
    stream_bytes.delete();
    add_le32(32'd0);
    add_le32(32'd0);
    stream_bytes.push_back(8'h33);
    send_stream(-1);
    settle();
    write_caps(32'hFFFF_FFFF, 32'h10);
    stream_bytes.delete();
    add_le32(32'hFFFF_FFFF);
    add_le32(32'h11);
    send_stream(-1);
    settle();
    write_caps(32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  task automatic test_backpressure();
    settle();
    tx_no_gaps = 1'b1;
    rx_no_stalls = 1'b1;
    hold_req = 150;
    stream_bytes.delete();
    add_le32(32'd7);
    add_le32(32'd9);
    add_token(24'($urandom), 32'd3, 1'b0, 32'd40, 1'b0);
    add_literals(39);
    add_token(24'($urandom), 32'd0, 1'b1, 32'd0, 1'b1);
    send_stream(-1);
    drain_results();
    tx_no_gaps = 1'b0;
    rx_no_stalls = 1'b0;
  endtask

  task automatic test_drain_pause();
    stream_bytes.delete();
    add_le32(32'd3);
    add_le32(32'd3);
    add_token(24'($urandom), 32'd4, 1'b0, 32'd7, 1'b0);
    add_literals(6);
    add_token(24'($urandom), 32'd9, 1'b0, 32'd0, 1'b1);
    send_stream(16);
  endtask

  task automatic test_random_streams();
    int n;
    n = 0;
    while (stream_items < 1000) begin
      if (n % 6 == 5) begin
        settle();
        write_caps(pick_cap(), pick_cap());
      end
      play_random_stream();
      n++;
    end
  endtask

  initial begin
    clk_i = 1'b0;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_index_i = rsd_pkg::CfgOutputCapacity;
    cfg_data_i = 32'd0;
    in_valid_i = 1'b0;
    stream_start_i = 1'b0;
    in_byte_i = 8'd0;
    hold_req = 0;
    tx_no_gaps = 1'b0;
    rx_no_stalls = 1'b0;
    stream_items = 0;
    mismatch_count = 0;
    phase_q = PhHalt;
    field_pos = 2'd0;
    field_acc = 32'd0;
    hdr_orig_size = 32'd0;
    tok_symbol = 24'd0;
    tok_count = 32'd0;
    lits_left = 32'd0;
    out_cap = 32'hFFFF_FFFF;
    in_cap = 32'hFFFF_FFFF;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_halted_bytes();
    test_token_forms();
    test_end_by_count();
    test_restart_mid_stream();
    test_header_limits();
    test_backpressure();
    test_drain_pause();
    test_random_streams();

    drain_results();
    repeat (6) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rsd_pkg.sv
sv/rsd_parser.sv
sv/rsd_result_fifo.sv
sv/rle_24bit_symbol_stream_decoder_top.sv
sim/testbench.sv
